>>> hw/rtl/sha256_stream_hasher_unit_assert.svh
// Assertion macros used by the checker file.
`ifndef SHA256_STREAM_HASHER_UNIT_ASSERT_SVH
`define SHA256_STREAM_HASHER_UNIT_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define SHS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define SHS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

>>> hw/rtl/shs_pkg.sv
// ----------------------------------------------------------------------------
// shs_pkg
// Types and constants for the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
`default_nettype none
package shs_pkg;

   localparam int QueueDepth = 4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       end_of_message;
   } item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_ADD,
      ST_PAD,
      ST_EMIT
   } back_state_type;

   function automatic logic [31:0] round_k(input logic [5:0] idx);
      logic [31:0] k;
      case (idx)
         6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
         6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
         6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
         6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
         6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
         6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
         6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
         6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
         6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
         6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
         6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
         6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
         default: k = 32'hc67178f2;
      endcase
      return k;
   endfunction

   function automatic logic [31:0] start_iv(input logic [2:0] idx);
      logic [31:0] v;
      case (idx)
         3'd0: v = 32'h6a09e667; 3'd1: v = 32'hbb67ae85;
         3'd2: v = 32'h3c6ef372; 3'd3: v = 32'ha54ff53a;
         3'd4: v = 32'h510e527f; 3'd5: v = 32'h9b05688c;
         3'd6: v = 32'h1f83d9ab; default: v = 32'h5be0cd19;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

>>> hw/rtl/sha256_stream_hasher_unit.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher_unit
// SHA-256 of a byte stream, digest given as eight 32-bit words.
// ----------------------------------------------------------------------------
// Bytes go in through a four-entry queue at one a cycle into the block
// buffer; the 64th byte of a block starts a compression of 64 rounds and a
// final add, done by the single round unit, during which input waits in the
// queue. An end-of-message item costs a padding step and one compression
// per final block, one block or two when 56 or more bytes are buffered, then
// the eight digest words follow, one per pop.
`default_nettype none
module sha256_stream_hasher_unit
   import shs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_byte_present,
   input  wire logic        req_end_of_message,
   output logic             empty,
   input  wire logic        pop,
   output logic [31:0]      rsp_digest_word,
   output logic [2:0]       rsp_word_index,
   output logic             rsp_last_word
);
   item_type item, head;
   logic     avail, deq;

   assign item = '{data_byte: req_data_byte, byte_present: req_byte_present,
                   end_of_message: req_end_of_message};

   shs_front u_front (
      .clock, .reset, .push, .item, .full, .deq, .avail, .head
   );

   shs_core u_core (
      .clock, .reset, .avail, .head, .deq,
      .rsp_empty(empty), .rsp_pop(pop),
      .rsp_digest_word, .rsp_word_index, .rsp_last_word
   );
endmodule
`default_nettype wire

>>> hw/rtl/shs_front.sv
// ----------------------------------------------------------------------------
// shs_front
// Input stage and item queue: drops items that carry neither byte nor end.
// ----------------------------------------------------------------------------
`default_nettype none
module shs_front
   import shs_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire item_type item,
   output logic          full,
   input  wire logic     deq,
   output logic          avail,
   output item_type      head
);
   localparam int AW = $clog2(QueueDepth);

   item_type       mem_ff [QueueDepth];
   logic [AW-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]    cnt_ff, cnt_in;
   logic           wr_en, rd_en;

   assign full  = (cnt_ff == (AW+1)'(QueueDepth));
   assign avail = (cnt_ff != '0);
   assign head  = mem_ff[rd_ff];
   assign wr_en = push && !full && (item.byte_present || item.end_of_message);
   assign rd_en = deq && avail;

   always_comb begin
      wr_in  = wr_en ? wr_ff + 1'b1 : wr_ff;
      rd_in  = rd_en ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (AW+1)'(wr_en) - (AW+1)'(rd_en);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (wr_en) mem_ff[wr_ff] <= item;
   end
endmodule
`default_nettype wire

>>> hw/rtl/shs_core.sv
// ----------------------------------------------------------------------------
// shs_core
// Back end: byte packing, padding, 64-round compression and digest output.
// ----------------------------------------------------------------------------
`default_nettype none
module shs_core
   import shs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        avail,
   input  wire item_type    head,
   output logic             deq,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [31:0]      rsp_digest_word,
   output logic [2:0]       rsp_word_index,
   output logic             rsp_last_word
);
   back_state_type state_ff, state_in;
   logic [31:0] blk_ff [16];
   logic [31:0] w_ff [16];
   logic [31:0] v_ff [8];
   logic [31:0] h_ff [8];
   logic [63:0] cnt_ff;
   logic [6:0]  rnd_ff;
   logic        pad_done_ff;   // final block in progress
   logic        closing_ff;    // end seen, padding pending
   logic        len_blk_ff;    // length spilled into a block of its own
   logic [2:0]  idx_ff;

   logic [5:0]  pos;
   logic [3:0]  wi;
   logic [1:0]  bi;
   logic        fits;
   logic [31:0] pad_word;
   logic [31:0] w_new, a, b, s1, ch, s0, maj, t1, t2;

   assign pos  = cnt_ff[8:3];
   assign wi   = pos[5:2];
   assign bi   = pos[1:0];
   assign fits = (pos < 6'd56);

   // buffered bytes of the current word kept, 0x80 after them
   always_comb begin
      case (bi)
         2'd0: pad_word = 32'h80000000;
         2'd1: pad_word = {blk_ff[wi][31:24], 24'h800000};
         2'd2: pad_word = {blk_ff[wi][31:16], 16'h8000};
         default: pad_word = {blk_ff[wi][31:8], 8'h80};
      endcase
   end

   always_comb begin
      a = w_ff[4'(rnd_ff[3:0] - 4'd2)];
      b = w_ff[4'(rnd_ff[3:0] - 4'd15)];
      if (rnd_ff < 7'd16) w_new = blk_ff[rnd_ff[3:0]];
      else w_new = ({a[16:0], a[31:17]} ^ {a[18:0], a[31:19]} ^ (a >> 10))
                 + w_ff[4'(rnd_ff[3:0] - 4'd7)]
                 + ({b[6:0], b[31:7]} ^ {b[17:0], b[31:18]} ^ (b >> 3))
                 + w_ff[rnd_ff[3:0]];
      s1  = {v_ff[4][5:0], v_ff[4][31:6]} ^ {v_ff[4][10:0], v_ff[4][31:11]}
          ^ {v_ff[4][24:0], v_ff[4][31:25]};
      ch  = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      t1  = v_ff[7] + s1 + ch + round_k(rnd_ff[5:0]) + w_new;
      s0  = {v_ff[0][1:0], v_ff[0][31:2]} ^ {v_ff[0][12:0], v_ff[0][31:13]}
          ^ {v_ff[0][21:0], v_ff[0][31:22]};
      maj = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t2  = s0 + maj;
   end

   always_comb begin
      state_in = state_ff;
      deq      = 1'b0;
      case (state_ff)
         ST_IDLE: if (avail) begin
            deq = 1'b1;
            if (head.byte_present && pos == 6'd63) state_in = ST_ROUND;
            else if (head.end_of_message) state_in = ST_PAD;
         end
         ST_ROUND: if (rnd_ff == 7'd63) state_in = ST_ADD;
         ST_ADD: begin
            if (pad_done_ff) state_in = ST_EMIT;
            else if (closing_ff) state_in = ST_PAD;
            else state_in = ST_IDLE;
         end
         ST_PAD: state_in = ST_ROUND;
         ST_EMIT: if (rsp_pop && idx_ff == 3'd7) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_empty       = (state_ff != ST_EMIT);
   assign rsp_digest_word = h_ff[idx_ff];
   assign rsp_word_index  = idx_ff;
   assign rsp_last_word   = (idx_ff == 3'd7);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         cnt_ff      <= '0;
         rnd_ff      <= '0;
         pad_done_ff <= 1'b0;
         closing_ff  <= 1'b0;
         len_blk_ff  <= 1'b0;
         idx_ff      <= '0;
         for (int i = 0; i < 8; i++) h_ff[i] <= start_iv(3'(i));
      end else begin
         state_ff <= state_in;
         case (state_ff)
            ST_IDLE: if (avail) begin
               if (head.byte_present) begin
                  case (bi)
                     2'd0: blk_ff[wi][31:24] <= head.data_byte;
                     2'd1: blk_ff[wi][23:16] <= head.data_byte;
                     2'd2: blk_ff[wi][15:8]  <= head.data_byte;
                     default: blk_ff[wi][7:0] <= head.data_byte;
                  endcase
                  cnt_ff <= cnt_ff + 64'd8;
               end
               closing_ff <= head.end_of_message;
               for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
            end
            ST_ROUND: begin
               w_ff[rnd_ff[3:0]] <= w_new;
               v_ff[7] <= v_ff[6];
               v_ff[6] <= v_ff[5];
               v_ff[5] <= v_ff[4];
               v_ff[4] <= v_ff[3] + t1;
               v_ff[3] <= v_ff[2];
               v_ff[2] <= v_ff[1];
               v_ff[1] <= v_ff[0];
               v_ff[0] <= t1 + t2;
               rnd_ff  <= (rnd_ff == 7'd63) ? 7'd0 : rnd_ff + 7'd1;
            end
            ST_ADD: begin
               for (int i = 0; i < 8; i++) begin
                  h_ff[i] <= h_ff[i] + v_ff[i];
                  v_ff[i] <= h_ff[i] + v_ff[i];
               end
            end
            ST_PAD: begin
               // 0x80 at pos, zeros after; length if it fits, else in a block of its own
               for (int j = 0; j < 16; j++) begin
                  if (len_blk_ff) begin
                     blk_ff[j] <= (j == 14) ? cnt_ff[63:32] :
                                  (j == 15) ? cnt_ff[31:0] : '0;
                  end else if (4'(j) == wi) begin
                     blk_ff[j] <= pad_word;
                  end else if (4'(j) > wi) begin
                     if (fits && j == 14) blk_ff[j] <= cnt_ff[63:32];
                     else if (fits && j == 15) blk_ff[j] <= cnt_ff[31:0];
                     else blk_ff[j] <= '0;
                  end
               end
               if (len_blk_ff || fits) begin
                  pad_done_ff <= 1'b1;
                  closing_ff  <= 1'b0;
                  len_blk_ff  <= 1'b0;
               end else begin
                  len_blk_ff <= 1'b1;
               end
            end
            ST_EMIT: if (rsp_pop) begin
               idx_ff <= idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  for (int i = 0; i < 8; i++) h_ff[i] <= start_iv(3'(i));
                  cnt_ff      <= '0;
                  pad_done_ff <= 1'b0;
               end
            end
            default: ;
         endcase
      end
   end
endmodule
`default_nettype wire

>>> hw/rtl/shs_checker.sv
// ----------------------------------------------------------------------------
// shs_checker
// Port-level checks on the digest stream.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sha256_stream_hasher_unit_assert.svh"
module shs_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        empty,
   input wire logic        pop,
   input wire logic [2:0]  rsp_word_index,
   input wire logic        rsp_last_word
);
   `SHS_ASSERT_IMP(a_last, clock, reset, !empty, rsp_last_word == (rsp_word_index == 3'd7), "last flag")
   `SHS_ASSERT_NEXT(a_step, clock, reset, !empty && pop && !rsp_last_word, !empty && rsp_word_index == $past(rsp_word_index) + 3'd1, "word order")
   `SHS_ASSERT_NEXT(a_hold, clock, reset, !empty && !pop, !empty && $stable(rsp_word_index), "held word")
endmodule
bind sha256_stream_hasher_unit shs_checker u_chk (.*);
`default_nettype wire

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives byte streams into the SHA-256 stream hasher and checks every digest
// word against a behavioural SHA-256 held in the bench. Covers empty
// messages, byte-less closing items, padding that needs a second block,
// multi-block messages and idle items, with random stalls on both sides.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
   import shs_pkg::*;

   localparam int CycleLimit = 2000000;

   logic        clock;
   logic        reset;
   logic        push;
   logic        full;
   logic [7:0]  req_data_byte;
   logic        req_byte_present;
   logic        req_end_of_message;
   logic        empty;
   logic        pop;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;

   typedef struct {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_word_type;

   // Bench-side hash state
   logic [31:0] hash_state [8];
   logic [7:0]  block_buf [64];
   logic [63:0] bit_count;
   digest_word_type digest_queue [$];
   int error_count;
   int cycle_count;

   sha256_stream_hasher_unit i_dut (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_data_byte(req_data_byte), .req_byte_present(req_byte_present),
      .req_end_of_message(req_end_of_message), .empty(empty), .pop(pop),
      .rsp_digest_word(rsp_digest_word), .rsp_word_index(rsp_word_index),
      .rsp_last_word(rsp_last_word)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [31:0] ror32(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] sha_const(int t);
      logic [31:0] k [64];
      k = '{32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
            32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
            32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
            32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
            32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
            32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
            32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
            32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
            32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
            32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      return k[t];
   endfunction

   function automatic void load_iv();
      hash_state = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                     32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      bit_count = '0;
   endfunction

   function automatic void compress();
      logic [31:0] w [16];
      logic [31:0] v [8];
      logic [31:0] x, a, b, t1, t2;
      for (int i = 0; i < 8; i++) v[i] = hash_state[i];
      for (int t = 0; t < 64; t++) begin
         if (t < 16) begin
            x = {block_buf[4*t], block_buf[4*t+1], block_buf[4*t+2], block_buf[4*t+3]};
         end else begin
            a = w[(t - 2) & 15];
            b = w[(t - 15) & 15];
            x = (ror32(a, 17) ^ ror32(a, 19) ^ (a >> 10)) + w[(t - 7) & 15]
                + (ror32(b, 7) ^ ror32(b, 18) ^ (b >> 3)) + w[t & 15];
         end
         w[t & 15] = x;
         t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
              + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_const(t) + x;
         t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
              + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hash_state[i] += v[i];
   endfunction

   function automatic void predict_digest(logic [7:0] data, logic present, logic eom);
      int pos;
      digest_word_type dw;
      if (present) begin
         pos = int'(bit_count[8:3]);
         block_buf[pos] = data;
         bit_count += 64'd8;
         if (pos == 63) compress();
      end
      if (eom) begin
         pos = int'(bit_count[8:3]);
         block_buf[pos] = 8'h80;
         for (int i = pos + 1; i < 64; i++) block_buf[i] = 8'h00;
         if (pos >= 56) begin
            compress();
            for (int i = 0; i < 56; i++) block_buf[i] = 8'h00;
         end
         for (int i = 0; i < 8; i++) block_buf[56 + i] = bit_count[63 - 8*i -: 8];
         compress();
         for (int i = 0; i < 8; i++) begin
            dw.word = hash_state[i];
            dw.index = 3'(i);
            dw.last = (i == 7);
            digest_queue.push_back(dw);
         end
         load_iv();
      end
   endfunction

   function automatic int pick_idle();
      if ($urandom_range(0, 9) < 6) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // One transaction on the request side
   task automatic send_item(logic [7:0] data, logic present, logic eom);
      int idle;
      push               <= 1'b1;
      req_data_byte      <= data;
      req_byte_present   <= present;
      req_end_of_message <= eom;
      @(posedge clock);
      while (full) @(posedge clock);
      predict_digest(data, present, eom);
      idle = pick_idle();
      if (idle > 0) begin
         push <= 1'b0;
         repeat (idle) @(posedge clock);
      end
   endtask

   task automatic send_message(int len, bit with_last_byte);
      for (int i = 0; i < len - 1; i++) send_item(8'($urandom), 1'b1, 1'b0);
      if (len > 0 && with_last_byte) send_item(8'($urandom), 1'b1, 1'b1);
      else begin
         if (len > 0) send_item(8'($urandom), 1'b1, 1'b0);
         send_item(8'($urandom), 1'b0, 1'b1);
      end
   endtask

   task automatic wait_drained();
      push <= 1'b0;
      while (digest_queue.size() != 0) @(posedge clock);
   endtask

   task automatic test_empty_message();
      send_item(8'h00, 1'b0, 1'b1);
      send_item(8'hff, 1'b0, 1'b1);
   endtask

   task automatic test_byte_extremes();
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'hff, 1'b1, 1'b0);
      send_item(8'h5a, 1'b0, 1'b0);       // idle item, no effect
      send_item(8'ha5, 1'b1, 1'b1);
      send_item(8'hff, 1'b1, 1'b1);
   endtask

   task automatic test_padding_overflow();
      send_message(55, 1'b1);
      send_message(56, 1'b0);
      send_message(64, 1'b1);
      wait_drained();                     // sender holds off until all digests are in
   endtask

   task automatic test_random_messages();
      int sent;
      int len;
      sent = 0;
      while (sent < 70) begin
         case ($urandom_range(0, 9))
            0: len = $urandom_range(55, 72);
            1: len = $urandom_range(120, 130);
            default: len = $urandom_range(0, 20);
         endcase
         send_message(len, $urandom_range(0, 1));
         if ($urandom_range(0, 3) == 0) send_item(8'($urandom), 1'b0, 1'b0);
         sent += len + 1;
      end
   endtask

   // Result checker
   always @(posedge clock) begin
      digest_word_type exp_dw;
      if (!reset && pop && !empty) begin
         if (digest_queue.size() == 0) begin
            $display("%0t: unexpected digest word %h", $time, rsp_digest_word);
            error_count++;
         end else begin
            exp_dw = digest_queue.pop_front();
            if (rsp_digest_word !== exp_dw.word) begin
               $display("%0t: digest_word expected %h actual %h", $time, exp_dw.word,
                        rsp_digest_word);
               error_count++;
            end
            if (rsp_word_index !== exp_dw.index) begin
               $display("%0t: word_index expected %0d actual %0d", $time, exp_dw.index,
                        rsp_word_index);
               error_count++;
            end
            if (rsp_last_word !== exp_dw.last) begin
               $display("%0t: last_word expected %b actual %b", $time, exp_dw.last,
                        rsp_last_word);
               error_count++;
            end
         end
      end
   end

   // Random stall on the result side
   initial begin
      int idle;
      pop = 1'b0;
      forever begin
         @(posedge clock);
         idle = pick_idle();
         if (idle == 0) pop <= 1'b1;
         else begin
            pop <= 1'b0;
            repeat (idle - 1) @(posedge clock);
         end
      end
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CycleLimit) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   initial begin
      error_count = 0;
      reset = 1'b1;
      push = 1'b0;
      req_data_byte = '0;
      req_byte_present = 1'b0;
      req_end_of_message = 1'b0;
      for (int i = 0; i < 64; i++) block_buf[i] = 8'h00;
      load_iv();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_message();
      test_byte_extremes();
      test_padding_overflow();
      test_random_messages();
      wait_drained();
      repeat (200) @(posedge clock);
      if (error_count == 0 && digest_queue.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire

>>> sim.f
+incdir+hw/rtl
hw/rtl/shs_pkg.sv
hw/rtl/shs_front.sv
hw/rtl/shs_core.sv
hw/rtl/sha256_stream_hasher_unit.sv
hw/rtl/shs_checker.sv
sim/testbench.sv
